// ===== design/bgi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the bilinear grid interpolator.
// No dependencies.
package bgi_pkg;

   localparam int KEY_W = 32;
   localparam int VOL_W = 32;
   localparam int WGT_W = 24;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_BAD_KEY = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_OUTSIDE = 3'd3;
   localparam logic [2:0] ST_MISSING = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0]        strike;
      logic [KEY_W-1:0]        expiry;
      logic signed [VOL_W-1:0] value;
   } quote_type;

endpackage

// ===== design/bgi_div.sv =====
`timescale 1ns / 1ps
// Restoring divider for Q0.24 weights: floor((num << 24) / den), num < den.
// One quotient bit per cycle. Uses bgi_pkg.
module bgi_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bgi_pkg::KEY_W-1:0]    num,
   input  logic [bgi_pkg::KEY_W-1:0]    den,
   output logic                         done,
   output logic [bgi_pkg::WGT_W-1:0]    quot
);

   logic [bgi_pkg::KEY_W-1:0] rem_ff;
   logic [bgi_pkg::KEY_W-1:0] den_ff;
   logic [bgi_pkg::WGT_W-1:0] quot_ff;
   logic [4:0]                cnt_ff;
   logic                      run_ff;
   logic                      done_ff;
   logic [bgi_pkg::KEY_W:0]   shifted;
   logic                      fits;

   assign shifted = {rem_ff, 1'b0};
   assign fits    = shifted >= {1'b0, den_ff};
   assign done    = done_ff;
   assign quot    = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= num;
            den_ff  <= den;
            quot_ff <= '0;
            cnt_ff  <= 5'(bgi_pkg::WGT_W);
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            if (fits) begin
               rem_ff  <= bgi_pkg::KEY_W'(shifted - {1'b0, den_ff});
               quot_ff <= {quot_ff[bgi_pkg::WGT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= shifted[bgi_pkg::KEY_W-1:0];
               quot_ff <= {quot_ff[bgi_pkg::WGT_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ===== design/bilinear_grid_interpolator_core.sv =====
`timescale 1ns / 1ps
// Bilinear interpolator over an irregular grid of quotes; top level.
// Uses bgi_pkg and bgi_div.
//
// One item at a time; the next beat is taken once the previous item has left its
// working states, while its result may still sit in the output register. Each
// memory read is an address state followed by a state that uses the registered
// data. Clear and rejected loads go straight to S_DONE. A stored load scans and
// shifts the strike and expiry axis entries; a query scans both axes and the
// stored quotes, then runs two weight divisions and three multiply-add blends.
module bilinear_grid_interpolator_core #(
   parameter int MAX_QUOTES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [bgi_pkg::KEY_W-1:0]           req_strike,
   input  logic [bgi_pkg::KEY_W-1:0]           req_expiry,
   input  logic signed [bgi_pkg::VOL_W-1:0]    req_implied_vol,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_status,
   output logic signed [bgi_pkg::VOL_W-1:0]    rsp_result_vol
);

   localparam int AW = (MAX_QUOTES > 1) ? $clog2(MAX_QUOTES) : 1;
   localparam int CW = $clog2(MAX_QUOTES + 1);
   localparam int KW = bgi_pkg::KEY_W;
   localparam int VW = bgi_pkg::VOL_W;
   localparam int WW = bgi_pkg::WGT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_INS_RD, S_INS_CMP, S_SH_RD, S_SH_WR,
      S_QB_RD, S_QB_CMP, S_QF_RD, S_QF_CMP,
      S_DV_GO, S_DV_WAIT, S_BL_MUL, S_BL_ADD, S_DONE
   } state_type;

   bgi_pkg::quote_type quote_mem [MAX_QUOTES];
   logic [KW-1:0]      strike_mem [MAX_QUOTES];
   logic [KW-1:0]      expiry_mem [MAX_QUOTES];

   state_type               state_ff;
   logic                    sel_ff;
   logic [KW-1:0]           key_s_ff, key_e_ff;
   logic [CW-1:0]           qcnt_ff, scnt_ff, ecnt_ff;
   logic [CW-1:0]           pos_ff, idx_ff;
   logic [KW-1:0]           prev_ff;
   logic [KW-1:0]           sl_ff, sh_ff, el_ff, eh_ff;
   logic [3:0]              found_ff;
   logic signed [VW-1:0]    v_ff [4];
   logic [WW-1:0]           ws_ff, we_ff;
   logic signed [VW-1:0]    lowv_ff, highv_ff;
   logic [1:0]              bstep_ff;
   logic signed [57:0]      p_ff;
   logic [2:0]              st_ff;
   logic signed [VW-1:0]    res_ff;
   logic                    rsp_valid_ff;
   logic [2:0]              rsp_status_ff;
   logic signed [VW-1:0]    rsp_vol_ff;
   logic [KW-1:0]           s_rd_ff, e_rd_ff;
   bgi_pkg::quote_type      q_rd_ff;

   logic                    accept;
   logic [KW-1:0]           ax_rd, ax_key;
   logic [CW-1:0]           ax_n, idx_m1;
   logic [AW-1:0]           ax_ra, ax_wa, q_ra, q_wa;
   logic [KW-1:0]           ax_wd;
   logic                    ax_we, q_we, load_ok;
   bgi_pkg::quote_type      q_wd;
   logic [3:0]              hit;
   logic [KW-1:0]           dv_num, dv_den;
   logic                    dv_start, dv_done;
   logic [WW-1:0]           dv_quot;
   logic signed [VW-1:0]    bl_a, bl_b, bl_r;
   logic [WW-1:0]           bl_w;
   logic signed [32:0]      bl_d;
   logic signed [57:0]      bl_p;

   assign req_stall      = state_ff != S_IDLE;
   assign accept         = req_valid && !req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_result_vol = rsp_vol_ff;

   assign load_ok = (req_strike != '0) && (req_expiry != '0)
                    && (qcnt_ff != CW'(MAX_QUOTES));
   assign ax_rd   = sel_ff ? e_rd_ff : s_rd_ff;
   assign ax_key  = sel_ff ? key_e_ff : key_s_ff;
   assign ax_n    = sel_ff ? ecnt_ff : scnt_ff;
   assign idx_m1  = idx_ff - CW'(1);

   always_comb begin
      ax_ra = pos_ff[AW-1:0];
      ax_wa = pos_ff[AW-1:0];
      ax_wd = ax_key;
      ax_we = 1'b0;
      case (state_ff)
         S_QB_RD: ax_ra = idx_ff[AW-1:0];
         S_SH_RD: begin
            ax_ra = idx_m1[AW-1:0];
            ax_we = !(idx_ff > pos_ff);
         end
         S_SH_WR: begin
            ax_wa = idx_ff[AW-1:0];
            ax_wd = ax_rd;
            ax_we = 1'b1;
         end
         default: ;
      endcase
   end

   assign q_ra = idx_ff[AW-1:0];
   assign q_wa = qcnt_ff[AW-1:0];
   assign q_we = accept && (req_action == bgi_pkg::ACT_LOAD) && load_ok;
   assign q_wd = '{strike: req_strike, expiry: req_expiry, value: req_implied_vol};

   always_ff @(posedge clock) begin
      if (q_we) quote_mem[q_wa] <= q_wd;
      q_rd_ff <= quote_mem[q_ra];
   end

   always_ff @(posedge clock) begin
      if (ax_we && !sel_ff) strike_mem[ax_wa] <= ax_wd;
      s_rd_ff <= strike_mem[ax_ra];
   end

   always_ff @(posedge clock) begin
      if (ax_we && sel_ff) expiry_mem[ax_wa] <= ax_wd;
      e_rd_ff <= expiry_mem[ax_ra];
   end

   assign hit[0] = (q_rd_ff.strike == sl_ff) && (q_rd_ff.expiry == el_ff);
   assign hit[1] = (q_rd_ff.strike == sh_ff) && (q_rd_ff.expiry == el_ff);
   assign hit[2] = (q_rd_ff.strike == sl_ff) && (q_rd_ff.expiry == eh_ff);
   assign hit[3] = (q_rd_ff.strike == sh_ff) && (q_rd_ff.expiry == eh_ff);

   assign dv_num   = sel_ff ? key_e_ff - el_ff : key_s_ff - sl_ff;
   assign dv_den   = sel_ff ? eh_ff - el_ff : sh_ff - sl_ff;
   assign dv_start = state_ff == S_DV_GO;

   bgi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (dv_den),
      .done  (dv_done),
      .quot  (dv_quot)
   );

   always_comb begin
      case (bstep_ff)
         2'd0: begin
            bl_a = v_ff[0];
            bl_b = v_ff[1];
            bl_w = ws_ff;
         end
         2'd1: begin
            bl_a = v_ff[2];
            bl_b = v_ff[3];
            bl_w = ws_ff;
         end
         default: begin
            bl_a = lowv_ff;
            bl_b = highv_ff;
            bl_w = we_ff;
         end
      endcase
   end

   assign bl_d = 33'(bl_b) - 33'(bl_a);
   assign bl_p = 58'(bl_d) * 58'($signed({1'b0, bl_w}));
   assign bl_r = bl_a + $signed(p_ff[55:24]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         qcnt_ff      <= '0;
         scnt_ff      <= '0;
         ecnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
         pos_ff       <= '0;
         idx_ff       <= '0;
         found_ff     <= '0;
         bstep_ff     <= 2'd0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  key_s_ff <= req_strike;
                  key_e_ff <= req_expiry;
                  res_ff   <= '0;
                  st_ff    <= bgi_pkg::ST_OK;
                  sel_ff   <= 1'b0;
                  pos_ff   <= '0;
                  idx_ff   <= '0;
                  state_ff <= S_DONE;
                  case (req_action)
                     bgi_pkg::ACT_CLEAR: begin
                        qcnt_ff <= '0;
                        scnt_ff <= '0;
                        ecnt_ff <= '0;
                     end
                     bgi_pkg::ACT_LOAD: begin
                        if (req_strike == '0 || req_expiry == '0) begin
                           st_ff <= bgi_pkg::ST_BAD_KEY;
                        end else if (!load_ok) begin
                           st_ff <= bgi_pkg::ST_FULL;
                        end else begin
                           qcnt_ff  <= qcnt_ff + CW'(1);
                           state_ff <= S_INS_RD;
                        end
                     end
                     bgi_pkg::ACT_QUERY: begin
                        if (qcnt_ff == '0) st_ff <= bgi_pkg::ST_OUTSIDE;
                        else state_ff <= S_QB_RD;
                     end
                     default: ;
                  endcase
               end
            end
            S_INS_RD: begin
               if (pos_ff == ax_n) begin
                  idx_ff   <= ax_n;
                  state_ff <= S_SH_RD;
               end else begin
                  state_ff <= S_INS_CMP;
               end
            end
            S_INS_CMP: begin
               if (ax_rd < ax_key) begin
                  pos_ff   <= pos_ff + CW'(1);
                  state_ff <= S_INS_RD;
               end else if (ax_rd == ax_key) begin
                  if (!sel_ff) begin
                     sel_ff   <= 1'b1;
                     pos_ff   <= '0;
                     state_ff <= S_INS_RD;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  idx_ff   <= ax_n;
                  state_ff <= S_SH_RD;
               end
            end
            S_SH_RD: begin
               if (idx_ff > pos_ff) begin
                  state_ff <= S_SH_WR;
               end else begin
                  if (sel_ff) ecnt_ff <= ecnt_ff + CW'(1);
                  else scnt_ff <= scnt_ff + CW'(1);
                  if (!sel_ff) begin
                     sel_ff   <= 1'b1;
                     pos_ff   <= '0;
                     state_ff <= S_INS_RD;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_SH_WR: begin
               idx_ff   <= idx_m1;
               state_ff <= S_SH_RD;
            end
            S_QB_RD: begin
               if (idx_ff == ax_n) begin
                  st_ff    <= bgi_pkg::ST_OUTSIDE;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_QB_CMP;
               end
            end
            S_QB_CMP: begin
               if (ax_rd < ax_key) begin
                  prev_ff  <= ax_rd;
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_QB_RD;
               end else if (ax_rd != ax_key && idx_ff == '0) begin
                  st_ff    <= bgi_pkg::ST_OUTSIDE;
                  state_ff <= S_DONE;
               end else begin
                  if (sel_ff) begin
                     el_ff <= (ax_rd == ax_key) ? ax_rd : prev_ff;
                     eh_ff <= ax_rd;
                  end else begin
                     sl_ff <= (ax_rd == ax_key) ? ax_rd : prev_ff;
                     sh_ff <= ax_rd;
                  end
                  idx_ff   <= '0;
                  found_ff <= '0;
                  sel_ff   <= 1'b1;
                  state_ff <= sel_ff ? S_QF_RD : S_QB_RD;
               end
            end
            S_QF_RD: begin
               if (idx_ff == qcnt_ff) begin
                  if (&found_ff) begin
                     sel_ff   <= 1'b0;
                     state_ff <= S_DV_GO;
                  end else begin
                     st_ff    <= bgi_pkg::ST_MISSING;
                     state_ff <= S_DONE;
                  end
               end else begin
                  state_ff <= S_QF_CMP;
               end
            end
            S_QF_CMP: begin
               for (int k = 0; k < 4; k++) begin
                  if (!found_ff[k] && hit[k]) begin
                     found_ff[k] <= 1'b1;
                     v_ff[k]     <= q_rd_ff.value;
                  end
               end
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= S_QF_RD;
            end
            S_DV_GO: state_ff <= S_DV_WAIT;
            S_DV_WAIT: begin
               if (dv_done) begin
                  if (sel_ff) begin
                     we_ff    <= (dv_den == '0) ? '0 : dv_quot;
                     bstep_ff <= 2'd0;
                     state_ff <= S_BL_MUL;
                  end else begin
                     ws_ff    <= (dv_den == '0) ? '0 : dv_quot;
                     sel_ff   <= 1'b1;
                     state_ff <= S_DV_GO;
                  end
               end
            end
            S_BL_MUL: begin
               p_ff     <= bl_p;
               state_ff <= S_BL_ADD;
            end
            S_BL_ADD: begin
               case (bstep_ff)
                  2'd0: lowv_ff <= bl_r;
                  2'd1: highv_ff <= bl_r;
                  default: res_ff <= bl_r;
               endcase
               bstep_ff <= bstep_ff + 2'd1;
               state_ff <= (bstep_ff == 2'd2) ? S_DONE : S_BL_MUL;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= st_ff;
                  rsp_vol_ff    <= res_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
